// ===== hdl/wsm_pkg.sv =====
`default_nettype none
package wsm_pkg;

    localparam int MAX_PATTERN_CHARS = 64;
    localparam int MAX_TEXT_CHARS    = 256;

    localparam int CHAR_W = 16;

    // address widths (at least one bit) and count widths (hold the depth itself)
    localparam int PAT_AW = (MAX_PATTERN_CHARS > 1) ? $clog2(MAX_PATTERN_CHARS) : 1;
    localparam int TXT_AW = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;
    localparam int PAT_LW = $clog2(MAX_PATTERN_CHARS + 1);
    localparam int TXT_LW = $clog2(MAX_TEXT_CHARS + 1);

    localparam logic [PAT_LW-1:0] PAT_MAX = PAT_LW'(MAX_PATTERN_CHARS);
    localparam logic [TXT_LW-1:0] TXT_MAX = TXT_LW'(MAX_TEXT_CHARS);

    localparam logic [CHAR_W-1:0] CH_STAR = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_ANY  = 16'h003F;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] char_code;
        logic              has_char;
        logic              last;
    } in_t;

    typedef struct packed {
        logic matched;
        logic too_long;
    } out_t;

    // launch of one match walk
    typedef struct packed {
        logic              go;
        logic [PAT_LW-1:0] plen;
        logic [TXT_LW-1:0] tlen;
        logic              too_long;
    } wsm_go_t;

endpackage
`default_nettype wire

// ===== hdl/wsm_ram.sv =====
`default_nettype none
module wsm_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/wsm_walk.sv =====
`default_nettype none
module wsm_walk (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wsm_pkg::wsm_go_t             ctl,
    input  wire logic [wsm_pkg::CHAR_W-1:0]   p_data,
    input  wire logic [wsm_pkg::CHAR_W-1:0]   t_data,
    output logic      [wsm_pkg::PAT_AW-1:0]   p_addr,
    output logic      [wsm_pkg::TXT_AW-1:0]   t_addr,
    output logic                              active,
    output logic                              done,
    output wsm_pkg::out_t                     result
);
    import wsm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_TREAD = 3'd3;
    localparam logic [2:0] S_TEVAL = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [PAT_LW-1:0] pi_reg, pi_next;
    logic [PAT_LW-1:0] star_reg, star_next;
    logic [TXT_LW-1:0] ti_reg, ti_next;
    logic [TXT_LW-1:0] mark_reg, mark_next;
    logic              have_star_reg, have_star_next;
    logic [PAT_LW-1:0] plen_reg, plen_next;
    logic [TXT_LW-1:0] tlen_reg, tlen_next;
    logic              done_reg, done_next;
    out_t              result_reg, result_next;
    logic              pin;

    assign p_addr = pi_reg[PAT_AW-1:0];
    assign t_addr = ti_reg[TXT_AW-1:0];
    assign active = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign pin    = (pi_reg < plen_reg);

    always_comb
    begin
        state_next     = state_reg;
        pi_next        = pi_reg;
        star_next      = star_reg;
        ti_next        = ti_reg;
        mark_next      = mark_reg;
        have_star_next = have_star_reg;
        plen_next      = plen_reg;
        tlen_next      = tlen_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.go)
                begin
                    plen_next      = ctl.plen;
                    tlen_next      = ctl.tlen;
                    pi_next        = '0;
                    ti_next        = '0;
                    have_star_next = 1'b0;
                    if (ctl.too_long)
                    begin
                        done_next   = 1'b1;
                        result_next = '{matched: 1'b0, too_long: 1'b1};
                    end
                    else if (ctl.tlen == '0)
                    begin
                        state_next = S_TREAD;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_READ;
                if (pin && (p_data == CH_ANY || p_data == t_data))
                begin
                    ti_next = ti_reg + 1'b1;
                    pi_next = pi_reg + 1'b1;
                end
                else if (pin && p_data == CH_STAR)
                begin
                    have_star_next = 1'b1;
                    star_next      = pi_reg;
                    mark_next      = ti_reg;
                    pi_next        = pi_reg + 1'b1;
                end
                else if (have_star_reg)
                begin
                    pi_next   = star_reg + 1'b1;
                    mark_next = mark_reg + 1'b1;
                    ti_next   = mark_reg + 1'b1;
                end
                else
                begin
                    // mismatch with no star to fall back on
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{matched: 1'b0, too_long: 1'b0};
                end
                if (state_next == S_READ && ti_next >= tlen_reg)
                begin
                    state_next = S_TREAD;
                end
            end
            S_TREAD:
            begin
                state_next = S_TEVAL;
            end
            S_TEVAL:
            begin
                // skip trailing stars
                if (pin && p_data == CH_STAR)
                begin
                    pi_next    = pi_reg + 1'b1;
                    state_next = S_TREAD;
                end
                else
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '{matched: (pi_reg == plen_reg), too_long: 1'b0};
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pi_reg        <= pi_next;
        star_reg      <= star_next;
        ti_reg        <= ti_next;
        mark_reg      <= mark_next;
        have_star_reg <= have_star_next;
        plen_reg      <= plen_next;
        tlen_reg      <= tlen_next;
        result_reg    <= result_next;
    end

endmodule
`default_nettype wire

// ===== hdl/wildcard_string_matcher_unit.sv =====
`default_nettype none
// Channel   Ports                    Transaction
// -------   ----------------------   ----------------------------------------
// item      start, busy, item        taken when start is high and busy is low
// result    done, result             one cycle with done high, cannot stall
//
// Pattern and text characters load into their memories, one per accepted item.
// A text item with last set starts a match walk: busy is high while it launches,
// then for each step of the greedy match (one memory read, one compare in the
// shared step unit) and each trailing-star check, until the result is given,
// where steps count text advances, star marks and backtracks.
// An overflowed pattern or text gives its result with no walk: go_reg, then done_reg.
// Reset is asynchronous and needs no clearing pass; the result port never
// stalls, so busy is set only by the launch and the walk.
module wildcard_string_matcher_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire wsm_pkg::in_t item,
    output logic              done,
    output wsm_pkg::out_t     result
);
    import wsm_pkg::*;

    logic              accept;
    logic              go_reg, go_next;
    logic [PAT_LW-1:0] plen_reg, plen_next;
    logic              povf_reg, povf_next;
    logic              pclosed_reg, pclosed_next;
    logic [TXT_LW-1:0] tlen_reg, tlen_next;
    logic              tovf_reg, tovf_next;
    logic [PAT_LW-1:0] plen_eff;
    logic              p_we, t_we;
    logic [PAT_AW-1:0] p_raddr;
    logic [TXT_AW-1:0] t_raddr;
    logic [CHAR_W-1:0] p_rdata, t_rdata;
    logic              walk_active;
    wsm_go_t           ctl;

    assign accept   = start && !busy;
    assign busy     = go_reg || walk_active;
    assign plen_eff = pclosed_reg ? '0 : plen_reg;

    assign p_we = accept && item.mode == MODE_PATTERN && item.has_char && plen_eff < PAT_MAX;
    assign t_we = accept && item.mode == MODE_TEXT && item.has_char && tlen_reg < TXT_MAX;

    always_comb
    begin
        go_next      = 1'b0;
        plen_next    = plen_reg;
        povf_next    = povf_reg;
        pclosed_next = pclosed_reg;
        tlen_next    = tlen_reg;
        tovf_next    = tovf_reg;
        if (go_reg)
        begin
            // walk has latched the lengths; open a fresh text
            tlen_next = '0;
            tovf_next = 1'b0;
        end
        if (accept)
        begin
            if (item.mode == MODE_PATTERN)
            begin
                plen_next = plen_eff;
                if (pclosed_reg)
                begin
                    povf_next = 1'b0;
                end
                if (item.has_char)
                begin
                    if (p_we)
                    begin
                        plen_next = plen_eff + 1'b1;
                    end
                    else
                    begin
                        povf_next = 1'b1;
                    end
                end
                pclosed_next = item.last;
            end
            else
            begin
                if (item.has_char)
                begin
                    if (t_we)
                    begin
                        tlen_next = tlen_reg + 1'b1;
                    end
                    else
                    begin
                        tovf_next = 1'b1;
                    end
                end
                go_next = item.last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg      <= 1'b0;
            plen_reg    <= '0;
            povf_reg    <= 1'b0;
            pclosed_reg <= 1'b1;
            tlen_reg    <= '0;
            tovf_reg    <= 1'b0;
        end
        else
        begin
            go_reg      <= go_next;
            plen_reg    <= plen_next;
            povf_reg    <= povf_next;
            pclosed_reg <= pclosed_next;
            tlen_reg    <= tlen_next;
            tovf_reg    <= tovf_next;
        end
    end

    assign ctl = '{go: go_reg, plen: plen_reg, tlen: tlen_reg, too_long: povf_reg || tovf_reg};

    wsm_ram #(
        .DEPTH (MAX_PATTERN_CHARS),
        .WIDTH (CHAR_W)
    ) u_pat_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (plen_eff[PAT_AW-1:0]),
        .wdata (item.char_code),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    wsm_ram #(
        .DEPTH (MAX_TEXT_CHARS),
        .WIDTH (CHAR_W)
    ) u_txt_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (tlen_reg[TXT_AW-1:0]),
        .wdata (item.char_code),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    wsm_walk u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .p_data (p_rdata),
        .t_data (t_rdata),
        .p_addr (p_raddr),
        .t_addr (t_raddr),
        .active (walk_active),
        .done   (done),
        .result (result)
    );

endmodule
`default_nettype wire
